// ===== sv/pept_pkg.sv =====
// ----------------------------------------------------------------------------
// pept_pkg: shared types for the endpoint table
// Request codes, table entry layout and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package pept_pkg;

   // request codes carried on req_type
   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_HAS    = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   // match key: cpu, channel, port
   typedef struct packed {
      logic [7:0]  cpu;
      logic [7:0]  channel;
      logic [15:0] port;
   } key_type;

   // one stored table entry (56 bits)
   typedef struct packed {
      logic [7:0]  opcode;
      key_type     key;
      logic [15:0] topic;
   } entry_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;    // capture request, restart scan
      logic rd;      // read table slot at scan address
      logic commit;  // apply table update, issue response
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic addr_last;  // scan address is on the last slot
   } stat_type;

endpackage

`default_nettype wire

// ===== sv/pept_ctrl.sv =====
// ----------------------------------------------------------------------------
// pept_ctrl: request sequencer
// Walks each transaction through scan, drain and commit phases.
// ----------------------------------------------------------------------------
`default_nettype none

module pept_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output pept_pkg::cmd_type      cmd,
   input  wire pept_pkg::stat_type stat
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and command decode
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd = 1'b1;
            if (stat.addr_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last slot is compared this cycle
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/pept_dpath.sv =====
// ----------------------------------------------------------------------------
// pept_dpath: table storage and scan datapath
// Entry memory, per-slot valid bits, scan compare and update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module pept_dpath #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pept_pkg::cmd_type  cmd,
   output pept_pkg::stat_type      stat,
   input  wire logic [1:0]         req_type,
   input  wire logic [7:0]         req_entry_opcode,
   input  wire logic [7:0]         req_entry_cpu,
   input  wire logic [7:0]         req_entry_channel,
   input  wire logic [15:0]        req_entry_port,
   input  wire logic [15:0]        req_entry_topic,
   output logic                    rsp_strobe,
   output logic                    rsp_success
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // entry memory, no reset; valid bits gate every read
   pept_pkg::entry_type mem [TABLE_DEPTH];

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [TABLE_DEPTH-1:0] valid_in;

   // captured transaction
   logic [1:0]            req_type_ff;
   pept_pkg::entry_type   entry_ff;

   // scan pipeline
   logic [AW-1:0]         rd_addr_ff;
   logic [AW-1:0]         cmp_addr_ff;
   logic                  rd_vld_ff;
   pept_pkg::entry_type   rd_data_ff;

   // scan results
   logic                  match_found_ff;
   logic [AW-1:0]         match_idx_ff;
   logic                  slot_found_ff;
   logic [AW-1:0]         slot_idx_ff;

   logic                  rsp_strobe_ff;
   logic                  rsp_success_ff;
   logic                  rsp_success_in;

   logic                  cmp_valid;
   logic                  cmp_hit;
   logic                  cmp_free;
   logic                  wr_en;

   assign stat.addr_last = (rd_addr_ff == AW'(TABLE_DEPTH - 1));

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff          <= req_type;
         entry_ff.opcode      <= req_entry_opcode;
         entry_ff.key.cpu     <= req_entry_cpu;
         entry_ff.key.channel <= req_entry_channel;
         entry_ff.key.port    <= req_entry_port;
         entry_ff.topic       <= req_entry_topic;
      end
   end

   // scan address and read-valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_addr_ff <= '0;
      end else if (cmd.rd) begin
         rd_addr_ff <= rd_addr_ff + AW'(1);
      end
      cmp_addr_ff <= rd_addr_ff;
   end

   // memory: registered read, single write port
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
      if (wr_en) begin
         mem[slot_idx_ff] <= entry_ff;
      end
   end

   // compare stage: first valid match, first free-or-matching slot
   assign cmp_valid = valid_ff[cmp_addr_ff];
   assign cmp_hit   = rd_vld_ff && cmp_valid && (rd_data_ff.key == entry_ff.key);
   assign cmp_free  = rd_vld_ff && !cmp_valid;

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         match_found_ff <= 1'b0;
         slot_found_ff  <= 1'b0;
      end else begin
         if (cmp_hit && !match_found_ff) begin
            match_found_ff <= 1'b1;
         end
         if ((cmp_hit || cmp_free) && !slot_found_ff) begin
            slot_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_hit && !match_found_ff) begin
         match_idx_ff <= cmp_addr_ff;
      end
      if ((cmp_hit || cmp_free) && !slot_found_ff) begin
         slot_idx_ff <= cmp_addr_ff;
      end
   end

   // commit: clear old match, then store new entry
   assign wr_en = cmd.commit && (req_type_ff == pept_pkg::REQ_ADD) && slot_found_ff;

   always_comb begin
      valid_in       = valid_ff;
      rsp_success_in = 1'b0;
      if (cmd.commit) begin
         case (req_type_ff)
            pept_pkg::REQ_ADD: begin
               if (match_found_ff) begin
                  valid_in[match_idx_ff] = 1'b0;
               end
               if (slot_found_ff) begin
                  valid_in[slot_idx_ff] = (entry_ff.opcode != 8'd0);
               end
               rsp_success_in = slot_found_ff;
            end
            pept_pkg::REQ_REMOVE: begin
               if (match_found_ff) begin
                  valid_in[match_idx_ff] = 1'b0;
               end
               rsp_success_in = match_found_ff;
            end
            pept_pkg::REQ_HAS: begin
               rsp_success_in = match_found_ff;
            end
            default: begin
               rsp_success_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         rsp_strobe_ff <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      rsp_success_ff <= rsp_success_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_success = rsp_success_ff;

endmodule

`default_nettype wire

// ===== sv/pubsub_endpoint_table_core.sv =====
// ----------------------------------------------------------------------------
// pubsub_endpoint_table_core: publisher/subscriber endpoint table
// Associative table keyed by cpu, channel and port with add, remove and query.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Every transaction
// scans all TABLE_DEPTH slots through the single read port of the entry
// memory, one slot per cycle, then compares the last slot in the drain state
// and commits in the commit state; busy is high throughout. rsp_strobe pulses
// for one cycle with rsp_success in the first cycle with busy low; the receiver
// cannot stall it, and a new transaction may be started in that same cycle.
// Reset marks every slot free.
// ----------------------------------------------------------------------------
`default_nettype none

module pubsub_endpoint_table_core #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_entry_opcode,
   input  wire logic [7:0]  req_entry_cpu,
   input  wire logic [7:0]  req_entry_channel,
   input  wire logic [15:0] req_entry_port,
   input  wire logic [15:0] req_entry_topic,
   output logic             rsp_strobe,
   output logic             rsp_success
);

   pept_pkg::cmd_type  cmd;
   pept_pkg::stat_type stat;

   // sequencer
   pept_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   // table and scan datapath
   pept_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_entry_opcode  (req_entry_opcode),
      .req_entry_cpu     (req_entry_cpu),
      .req_entry_channel (req_entry_channel),
      .req_entry_port    (req_entry_port),
      .req_entry_topic   (req_entry_topic),
      .rsp_strobe        (rsp_strobe),
      .rsp_success       (rsp_success)
   );

endmodule

`default_nettype wire

// ===== dv/pubsub_endpoint_table_core_test.sv =====
// ----------------------------------------------------------------------------
// pubsub_endpoint_table_core_test: self-checking bench for the endpoint table
// Sends add, remove and query transactions through the start/busy port and
// compares every rsp_success pulse against an in-bench model of the table.
// A directed table covers the empty, full, replace, stale-slot and zero-opcode
// cases; random phases then work a small key pool so the table runs near full.
// ----------------------------------------------------------------------------
`default_nettype none

module pubsub_endpoint_table_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 1600;
   localparam int PHASES       = 4;
   localparam int POOL_SIZE    = 24;
   localparam int SETTLE_TICKS = TABLE_DEPTH + 8;
   localparam int CYCLE_LIMIT  = 400000;

   localparam pept_pkg::key_type KEY_A    = '{cpu: 8'h12, channel: 8'h34, port: 16'h5678};
   localparam pept_pkg::key_type KEY_B    = '{cpu: 8'h9A, channel: 8'hBC, port: 16'hDEF0};
   localparam pept_pkg::key_type KEY_MAX  = '{cpu: 8'hFF, channel: 8'hFF, port: 16'hFFFF};
   localparam pept_pkg::key_type KEY_ZERO = '{cpu: 8'h00, channel: 8'h00, port: 16'h0000};
   localparam pept_pkg::key_type KEY_NEAR = '{cpu: 8'h00, channel: 8'h00, port: 16'h0001};

   // one stimulus row; a literal result is used where it is obvious
   typedef struct {
      pept_pkg::req_code_type kind;
      pept_pkg::entry_type    ent;
      bit                     has_literal;
      bit                     literal;
   } txn_row_type;

   typedef struct {
      bit success;
      int seq;
   } pending_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   pept_pkg::req_code_type  req_type = pept_pkg::REQ_NONE;
   logic [7:0]              req_entry_opcode = '0;
   logic [7:0]              req_entry_cpu = '0;
   logic [7:0]              req_entry_channel = '0;
   logic [15:0]             req_entry_port = '0;
   logic [15:0]             req_entry_topic = '0;
   logic                    rsp_strobe;
   logic                    rsp_success;

   pept_pkg::entry_type     slot_table [TABLE_DEPTH];
   pending_type             pending_success [$];
   pept_pkg::key_type       key_pool [POOL_SIZE];
   pept_pkg::key_type       stray_keys [$];
   txn_row_type             directed_rows [$];
   int                      txn_seq = 0;
   int                      mismatch_count = 0;
   int                      cycle_count = 0;
   bit                      idling_on = 1'b1;

   pubsub_endpoint_table_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_entry_opcode(req_entry_opcode),
      .req_entry_cpu(req_entry_cpu),
      .req_entry_channel(req_entry_channel),
      .req_entry_port(req_entry_port),
      .req_entry_topic(req_entry_topic),
      .rsp_strobe(rsp_strobe),
      .rsp_success(rsp_success)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string what, int seq, bit want, bit got);
      $display("mismatch: %s (transaction %0d, expected success=%0b, got %0b)",
               what, seq, want, got);
      mismatch_count++;
   endtask

   // table model: lowest valid key match, lowest free slot
   function automatic bit predict_success(pept_pkg::req_code_type kind,
                                          pept_pkg::entry_type ent);
      int hit;
      int vacant;
      hit = -1;
      vacant = -1;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (hit < 0 && slot_table[i].opcode != 8'd0 && slot_table[i].key == ent.key)
            hit = i;
      case (kind)
         pept_pkg::REQ_ADD: begin
            if (hit >= 0)
               slot_table[hit].opcode = 8'd0;
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (vacant < 0 && slot_table[i].opcode == 8'd0)
                  vacant = i;
            if (vacant >= 0)
               slot_table[vacant] = ent;
            return vacant >= 0;
         end
         pept_pkg::REQ_REMOVE: begin
            if (hit >= 0)
               slot_table[hit].opcode = 8'd0;
            return hit >= 0;
         end
         pept_pkg::REQ_HAS: return hit >= 0;
         default: return 1'b0;
      endcase
   endfunction

   function automatic txn_row_type mk_row(pept_pkg::req_code_type kind,
                                          logic [7:0] opcode,
                                          pept_pkg::key_type key, logic [15:0] topic,
                                          bit has_literal = 1'b0, bit literal = 1'b0);
      txn_row_type r;
      r.kind = kind;
      r.ent.opcode = opcode;
      r.ent.key = key;
      r.ent.topic = topic;
      r.has_literal = has_literal;
      r.literal = literal;
      return r;
   endfunction

   // keys share cpu and channel values so partial matches are common
   function automatic void make_key_pool();
      logic [7:0]  cpus [2];
      logic [7:0]  chans [2];
      logic [15:0] ports [6];
      foreach (cpus[i]) cpus[i] = 8'($urandom);
      foreach (chans[i]) chans[i] = 8'($urandom);
      foreach (ports[i]) ports[i] = 16'($urandom);
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i].cpu = cpus[i % 2];
         key_pool[i].channel = chans[(i / 2) % 2];
         key_pool[i].port = ports[i / 4];
      end
   endfunction

   // present one transaction, hold it until taken, then log its expectation
   task automatic send_txn(txn_row_type r);
      bit predicted;
      if (idling_on && $urandom_range(0, 99) < 25) begin
         // drop start and stay idle until the block is ready again
         start <= 1'b0;
         do @(posedge clock); while (busy);
         repeat ($urandom_range(0, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= r.kind;
      req_entry_opcode <= r.ent.opcode;
      req_entry_cpu <= r.ent.key.cpu;
      req_entry_channel <= r.ent.key.channel;
      req_entry_port <= r.ent.key.port;
      req_entry_topic <= r.ent.topic;
      do @(posedge clock); while (busy);
      predicted = predict_success(r.kind, r.ent);
      pending_success.push_back('{success: r.has_literal ? r.literal : predicted,
                                  seq: txn_seq});
      txn_seq++;
   endtask

   task automatic send_random_txn();
      int          roll;
      txn_row_type r;
      roll = $urandom_range(0, 99);
      r.has_literal = 1'b0;
      r.literal = 1'b0;
      r.ent.opcode = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      r.ent.topic = 16'($urandom);
      if (roll < 92) begin
         // well-formed traffic on the key pool
         r.ent.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         roll = $urandom_range(0, 99);
         r.kind = (roll < 45) ? pept_pkg::REQ_ADD :
                  (roll < 75) ? pept_pkg::REQ_REMOVE :
                  (roll < 97) ? pept_pkg::REQ_HAS : pept_pkg::REQ_NONE;
      end else begin
         // noise: any key, any request code
         r.ent.key = pept_pkg::key_type'($urandom);
         r.kind = pept_pkg::req_code_type'($urandom_range(0, 3));
         if (r.kind == pept_pkg::REQ_ADD)
            stray_keys.push_back(r.ent.key);
      end
      send_txn(r);
   endtask

   // free everything this phase may have left, then drain all responses
   task automatic retire_keys();
      foreach (key_pool[i])
         send_txn(mk_row(pept_pkg::REQ_REMOVE, 8'h00, key_pool[i], 16'h0000));
      foreach (stray_keys[i])
         send_txn(mk_row(pept_pkg::REQ_REMOVE, 8'h00, stray_keys[i], 16'h0000));
      stray_keys.delete();
      start <= 1'b0;
      while (pending_success.size() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      foreach (slot_table[i]) slot_table[i] = '0;
      make_key_pool();

      directed_rows = '{
         mk_row(pept_pkg::REQ_HAS,    8'hFF, KEY_A,    16'h1111, 1'b1, 1'b0),  // empty
         mk_row(pept_pkg::REQ_REMOVE, 8'hFF, KEY_A,    16'h1111, 1'b1, 1'b0),
         mk_row(pept_pkg::REQ_NONE,   8'hFF, KEY_MAX,  16'hFFFF, 1'b1, 1'b0),  // unused
         mk_row(pept_pkg::REQ_ADD,    8'hFF, KEY_A,    16'hFFFF, 1'b1, 1'b1),
         mk_row(pept_pkg::REQ_ADD,    8'h01, KEY_A,    16'h0000, 1'b1, 1'b1),  // replace
         mk_row(pept_pkg::REQ_HAS,    8'h00, KEY_A,    16'hAAAA, 1'b1, 1'b1),  // topic
         mk_row(pept_pkg::REQ_REMOVE, 8'h00, KEY_A,    16'h0000, 1'b1, 1'b1),
         mk_row(pept_pkg::REQ_REMOVE, 8'h00, KEY_A,    16'h0000, 1'b1, 1'b0),  // stale
         mk_row(pept_pkg::REQ_ADD,    8'h00, KEY_B,    16'h5555, 1'b1, 1'b1),  // zero op
         mk_row(pept_pkg::REQ_HAS,    8'h00, KEY_B,    16'h5555, 1'b1, 1'b0),
         mk_row(pept_pkg::REQ_ADD,    8'hFF, KEY_MAX,  16'hFFFF, 1'b1, 1'b1),
         mk_row(pept_pkg::REQ_ADD,    8'h01, KEY_ZERO, 16'h0000, 1'b1, 1'b1),
         mk_row(pept_pkg::REQ_HAS,    8'h01, KEY_NEAR, 16'h0000)
      };
      // fill the remaining slots
      for (int i = 0; i < TABLE_DEPTH - 2; i++) begin
         directed_rows.push_back(mk_row(pept_pkg::REQ_ADD, 8'($urandom_range(1, 255)),
                                        '{cpu: 8'(i), channel: 8'hA5,
                                          port: 16'(i + 256)}, 16'($urandom)));
         stray_keys.push_back('{cpu: 8'(i), channel: 8'hA5, port: 16'(i + 256)});
      end
      directed_rows.push_back(mk_row(pept_pkg::REQ_ADD, 8'h33, KEY_A, 16'h0101,
                                     1'b1, 1'b0));
      directed_rows.push_back(mk_row(pept_pkg::REQ_ADD, 8'h02, KEY_MAX, 16'h0202,
                                     1'b1, 1'b1));
      directed_rows.push_back(mk_row(pept_pkg::REQ_HAS, 8'h00, KEY_A, 16'h0000,
                                     1'b1, 1'b0));
      stray_keys.push_back(KEY_MAX);
      stray_keys.push_back(KEY_ZERO);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_txn(directed_rows[i]);
      retire_keys();

      // random phases; the second runs with no idle gaps
      for (int p = 0; p < PHASES; p++) begin
         make_key_pool();
         idling_on = (p != 1);
         repeat (RANDOM_ITEMS / PHASES) send_random_txn();
         retire_keys();
      end

      repeat (SETTLE_TICKS) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // response checker
   always @(posedge clock) begin
      pending_type head;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_success.size() == 0) begin
            report_mismatch("response with no transaction outstanding", -1, 1'b0,
                            rsp_success);
         end else begin
            head = pending_success.pop_front();
            if (rsp_success !== head.success)
               report_mismatch("rsp_success", head.seq, head.success, rsp_success);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout: %0d responses outstanding", pending_success.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule

`default_nettype wire
